@@ hdl/fifo_page_replacement_macros.svh @@
`ifndef FIFO_PAGE_REPLACEMENT_MACROS_SVH
`define FIFO_PAGE_REPLACEMENT_MACROS_SVH

// clocked check, disabled while the active-low reset is asserted
`define FPR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check on the block clock and reset
`define FPR_ASSERT(lbl, prop, msg) `FPR_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

@@ hdl/fpr_pkg.sv @@
`timescale 1ns / 1ps

package fpr_pkg;

    localparam int CFG_W      = 5;
    localparam int IN_PAGE_W  = 16;
    localparam int SLOT_OUT_W = 4;
    localparam int CNT_W      = 32;
    localparam int OUT_W      = 56;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

    typedef struct packed {
        logic vld;
        logic hit;
        logic vic_valid;
    } t_tok_ctl;

endpackage

@@ hdl/fifo_page_replacement.sv @@
`timescale 1ns / 1ps

// fifo page replacement unit
// s_axis carries one page reference per transfer (page number in tdata[15:0]).
// m_axis returns one result per reference: fault flag, frame slot, eviction
// flag, evicted page and the saturating fault count.
// i_cfg_wr_en / i_cfg_wr_data set the number of frames in use; write it only
// while idle and reset the block afterwards.
// the reference runs down a row of FRAMES cells, one cell per cycle; each cell
// holds one frame, compares it and picks up the victim page as the token passes.
// the result is registered in the output register at the end of the cell row;
// one reference is in flight at a time.
// a result waits in a one-entry holding register if the receiver stalls;
// s_axis_tready stays low until that result has moved to the output register.
// reset (synchronous, active low) empties all frames, clears the fault count
// and the replacement pointer, and sets frames in use to 4.
module fifo_page_replacement #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] page_number
    input  logic [fpr_pkg::IN_PAGE_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] fault, [4:1] frame_slot, [5] evicted_valid, [21:6] evicted_page,
    // [53:22] fault_total, [55:54] zero
    output logic [fpr_pkg::OUT_W-1:0]       m_axis_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [fpr_pkg::CFG_W-1:0]       i_cfg_wr_data
);

    `include "fifo_page_replacement_macros.svh"

    localparam int CFG_W  = fpr_pkg::CFG_W;
    localparam int PW     = (PAGE_BITS < fpr_pkg::IN_PAGE_W) ? PAGE_BITS : fpr_pkg::IN_PAGE_W;
    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int SLOT_W = (IDX_W > CFG_W) ? IDX_W : CFG_W;
    localparam int CAP_MAX_I = (FRAMES > 31) ? 31 : FRAMES;
    localparam logic [CFG_W-1:0] CAP_MAX = CFG_W'(CAP_MAX_I);

    fpr_pkg::t_tok_ctl       w_ctl      [0:FRAMES];
    logic [PW-1:0]           w_page     [0:FRAMES];
    logic [SLOT_W-1:0]       w_hit_slot [0:FRAMES];
    logic [SLOT_W-1:0]       w_vic_slot [0:FRAMES];
    logic [PW-1:0]           w_vic_page [0:FRAMES];

    logic [CFG_W-1:0]        r_cfg;
    logic [CFG_W-1:0]        r_filled;
    logic [CFG_W-1:0]        n_filled;
    logic [CFG_W-1:0]        r_oldest;
    logic [CFG_W-1:0]        n_oldest;
    logic [fpr_pkg::CNT_W-1:0] r_cnt;
    logic [fpr_pkg::CNT_W-1:0] n_cnt;
    logic [CFG_W-1:0]        r_vic;
    logic                    r_full;
    logic                    r_busy;
    logic                    n_busy;
    logic                    r_ovalid;
    logic                    n_ovalid;
    logic                    r_pend_v;
    logic                    n_pend_v;
    logic [fpr_pkg::OUT_W-1:0] r_odata;
    logic [fpr_pkg::OUT_W-1:0] r_pend;
    logic [fpr_pkg::OUT_W-1:0] w_res;

    logic [CFG_W-1:0]        w_cap;
    logic [CFG_W-1:0]        w_oldest_eff;
    logic                    w_accept;
    logic                    w_done;
    logic                    w_hit;
    logic                    w_out_free;
    logic [SLOT_W-1:0]       w_slot;
    logic                    w_ev_v;
    logic [fpr_pkg::IN_PAGE_W-1:0] w_ev_page;
    logic [CFG_W:0]          w_vic_inc;

    assign s_axis_tready = !r_busy;
    assign w_accept      = s_axis_tvalid && !r_busy;
    assign w_out_free    = !r_ovalid || m_axis_tready;

    always_comb begin
        if (r_cfg == '0) begin
            w_cap = CFG_W'(1);
        end else if (r_cfg > CAP_MAX) begin
            w_cap = CAP_MAX;
        end else begin
            w_cap = r_cfg;
        end
        w_oldest_eff = (r_oldest >= w_cap) ? '0 : r_oldest;
    end

    // token launched into the first cell
    always_comb begin
        w_ctl[0].vld       = w_accept;
        w_ctl[0].hit       = 1'b0;
        w_ctl[0].vic_valid = 1'b0;
        w_page[0]          = s_axis_tdata[PW-1:0];
        w_hit_slot[0]      = '0;
        w_vic_slot[0]      = SLOT_W'(w_oldest_eff);
        w_vic_page[0]      = '0;
    end

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        fpr_cell #(
            .PW     (PW),
            .SLOT_W (SLOT_W),
            .INDEX  (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[g]),
            .i_page     (w_page[g]),
            .i_hit_slot (w_hit_slot[g]),
            .i_vic_slot (w_vic_slot[g]),
            .i_vic_page (w_vic_page[g]),
            .o_ctl      (w_ctl[g+1]),
            .o_page     (w_page[g+1]),
            .o_hit_slot (w_hit_slot[g+1]),
            .o_vic_slot (w_vic_slot[g+1]),
            .o_vic_page (w_vic_page[g+1]),
            .i_wr_en    (w_done && !w_hit),
            .i_wr_slot  (w_slot),
            .i_wr_page  (w_page[FRAMES])
        );
    end

    // completion of the reference at the end of the row
    always_comb begin
        w_done    = w_ctl[FRAMES].vld;
        w_hit     = w_ctl[FRAMES].hit;
        w_vic_inc = {1'b0, r_vic} + {{CFG_W{1'b0}}, 1'b1};
        if (w_hit) begin
            w_slot = w_hit_slot[FRAMES];
        end else if (r_full) begin
            w_slot = SLOT_W'(r_vic);
        end else begin
            w_slot = SLOT_W'(r_filled);
        end
        w_ev_v    = !w_hit && r_full && w_ctl[FRAMES].vic_valid;
        w_ev_page = w_ev_v ? fpr_pkg::IN_PAGE_W'(w_vic_page[FRAMES]) : '0;

        n_filled = r_filled;
        n_oldest = r_oldest;
        n_cnt    = r_cnt;
        if (w_done && !w_hit) begin
            if (r_full) begin
                n_oldest = (w_vic_inc >= {1'b0, w_cap}) ? '0 : w_vic_inc[CFG_W-1:0];
            end else begin
                n_filled = r_filled + CFG_W'(1);
            end
            if (r_cnt != '1) begin
                n_cnt = r_cnt + fpr_pkg::CNT_W'(1);
            end
        end
        w_res = {2'b00, n_cnt, w_ev_page, w_ev_v, w_slot[fpr_pkg::SLOT_OUT_W-1:0], !w_hit};
    end

    always_comb begin
        n_busy   = r_busy;
        n_ovalid = r_ovalid;
        n_pend_v = r_pend_v;
        if (w_accept) begin
            n_busy = 1'b1;
        end
        if (w_done) begin
            if (w_out_free) begin
                n_ovalid = 1'b1;
                n_busy   = 1'b0;
            end else begin
                n_pend_v = 1'b1;
            end
        end else if (r_pend_v && w_out_free) begin
            n_ovalid = 1'b1;
            n_pend_v = 1'b0;
            n_busy   = 1'b0;
        end else if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= fpr_pkg::CFG_RESET;
            r_filled <= '0;
            r_oldest <= '0;
            r_cnt    <= '0;
            r_full   <= 1'b0;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_full <= (r_filled >= w_cap);
            end
            r_filled <= n_filled;
            r_oldest <= n_oldest;
            r_cnt    <= n_cnt;
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vic <= w_oldest_eff;
        end
        if (w_done && !w_out_free) begin
            r_pend <= w_res;
        end
        if (w_done && w_out_free) begin
            r_odata <= w_res;
        end else if (!w_done && r_pend_v && w_out_free) begin
            r_odata <= r_pend;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    `FPR_ASSERT(a_accept_sets_busy, w_accept |=> r_busy, "transfer accepted but block not busy")
    `FPR_ASSERT(a_token_only_busy, w_done |-> r_busy, "result token with no reference in flight")
    `FPR_ASSERT(a_pend_behind_out, r_pend_v |-> r_ovalid, "held result while output register empty")
    `FPR_ASSERT(a_filled_bound, r_filled <= CAP_MAX, "fill count beyond frame count")
    `FPR_ASSERT(a_evict_is_fault, (m_axis_tvalid && m_axis_tdata[5]) |-> m_axis_tdata[0], "eviction without fault")

endmodule

@@ hdl/fpr_cell.sv @@
`timescale 1ns / 1ps

module fpr_cell #(
    parameter int PW     = 16,
    parameter int SLOT_W = 5,
    parameter int INDEX  = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fpr_pkg::t_tok_ctl  i_ctl,
    input  logic [PW-1:0]      i_page,
    input  logic [SLOT_W-1:0]  i_hit_slot,
    input  logic [SLOT_W-1:0]  i_vic_slot,
    input  logic [PW-1:0]      i_vic_page,
    output fpr_pkg::t_tok_ctl  o_ctl,
    output logic [PW-1:0]      o_page,
    output logic [SLOT_W-1:0]  o_hit_slot,
    output logic [SLOT_W-1:0]  o_vic_slot,
    output logic [PW-1:0]      o_vic_page,
    input  logic               i_wr_en,
    input  logic [SLOT_W-1:0]  i_wr_slot,
    input  logic [PW-1:0]      i_wr_page
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

    logic [PW-1:0]     r_page;
    logic              r_valid;
    fpr_pkg::t_tok_ctl r_ctl;
    fpr_pkg::t_tok_ctl n_ctl;
    logic [PW-1:0]     r_tok_page;
    logic [SLOT_W-1:0] r_hit_slot;
    logic [SLOT_W-1:0] n_hit_slot;
    logic [SLOT_W-1:0] r_vic_slot;
    logic [PW-1:0]     r_vic_page;
    logic [PW-1:0]     n_vic_page;
    logic              w_match;
    logic              w_own_vic;
    logic              w_wr_here;

    assign w_match   = i_ctl.vld && !i_ctl.hit && r_valid && (r_page == i_page);
    assign w_own_vic = (i_vic_slot == MY_SLOT);
    assign w_wr_here = i_wr_en && (i_wr_slot == MY_SLOT);

    always_comb begin
        n_ctl.vld       = i_ctl.vld;
        n_ctl.hit       = i_ctl.hit || w_match;
        n_ctl.vic_valid = w_own_vic ? r_valid : i_ctl.vic_valid;
        n_hit_slot      = w_match ? MY_SLOT : i_hit_slot;
        n_vic_page      = w_own_vic ? r_page : i_vic_page;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ctl   <= '0;
        end else begin
            r_ctl <= n_ctl;
            if (w_wr_here) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_page <= i_page;
        r_hit_slot <= n_hit_slot;
        r_vic_slot <= i_vic_slot;
        r_vic_page <= n_vic_page;
        if (w_wr_here) begin
            r_page <= i_wr_page;
        end
    end

    assign o_ctl      = r_ctl;
    assign o_page     = r_tok_page;
    assign o_hit_slot = r_hit_slot;
    assign o_vic_slot = r_vic_slot;
    assign o_vic_page = r_vic_page;

endmodule
